### rtl/poi_pkg.sv
// Package with widths, constants and the arctangent table of the planar odometry integrator.
package poi_pkg;

  // Port field widths.
  localparam int unsigned VEL_W  = 32;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned DT_W   = 24;
  localparam int unsigned POS_W  = 48;
  localparam int unsigned ANG_W  = 32;

  // CORDIC datapath width: Q1.30 values with headroom for the gain growth.
  localparam int unsigned CW = 34;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Step limits of the CORDIC rotator.
  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned CORDIC_MAX_STEPS = 32;
  localparam int unsigned ATAN_IDX_W       = 5;

  // CORDIC start value: inverse gain, 0.6072529350 in Q1.30.
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  // Full turn over 2*pi, rounded: converts radians into binary angle units.
  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;

  // Arctangent of 2^-i as a binary angle, full turn equals 2^32.
  function automatic logic [ANG_W-1:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] val;
    case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

### rtl/poi_if.sv
// Valid/ready channel interfaces for odometry reports and pose results.
interface poi_in_if;
  import poi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]  vel_x;
  logic signed [VEL_W-1:0]  vel_y;
  logic signed [RATE_W-1:0] yaw_rate;
  logic        [DT_W-1:0]   elapsed;

  modport source (output valid, vel_x, vel_y, yaw_rate, elapsed, input ready);
  modport sink   (input valid, vel_x, vel_y, yaw_rate, elapsed, output ready);
endinterface

interface poi_out_if;
  import poi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic        [ANG_W-1:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

### rtl/poi_mult.sv
// Shared signed multiplier with a registered product.
module poi_mult (
  input  logic                               clk_i,
  input  logic signed [poi_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [poi_pkg::MUL_B_W-1:0] b_i,
  output logic signed [poi_pkg::MUL_P_W-1:0] p_o
);
  import poi_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### rtl/poi_cordic.sv
// Iterative CORDIC rotator that turns a binary angle into cosine and sine in Q1.30.
module poi_cordic #(
  parameter int unsigned CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [poi_pkg::ANG_W-1:0]     angle_i,
  output logic                          done_o,
  output logic signed [poi_pkg::CW-1:0] cos_o,
  output logic signed [poi_pkg::CW-1:0] sin_o
);
  import poi_pkg::*;

  localparam int unsigned STEPS_RUN =
    (CORDIC_STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS : CORDIC_STEPS;
  localparam int unsigned STEP_W = (STEPS_RUN > 1) ? $clog2(STEPS_RUN) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_RUN - 1);

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIX
  } cordic_state_e;

  cordic_state_e          state_q;
  logic [STEP_W-1:0]      step_q;
  logic [1:0]             quad_q;
  logic signed [CW-1:0]   x_q, y_q, z_q;
  logic signed [CW-1:0]   x_d, y_d, z_d;
  logic signed [CW-1:0]   x_sh, y_sh, atan_w;
  logic [ANG_W-1:0]       ang_bias, z_start;
  logic [1:0]             quad_start;

  // Quadrant split: the residual angle lands in [-1/8, 1/8) of a turn.
  assign ang_bias   = angle_i + ANG_W'(32'h2000_0000);
  assign quad_start = ang_bias[ANG_W-1:ANG_W-2];
  assign z_start    = angle_i - {quad_start, {(ANG_W-2){1'b0}}};

  // One micro-rotation per cycle through the shared shifters and adders.
  always_comb begin
    x_sh   = x_q >>> step_q;
    y_sh   = y_q >>> step_q;
    atan_w = CW'(atan_bam(ATAN_IDX_W'(step_q)));
    if (!z_q[CW-1]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - atan_w;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + atan_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_o  <= 1'b0;
    end else begin
      // Done is a one-cycle pulse that follows the quadrant fix-up.
      done_o <= (state_q == C_FIX);
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            x_q     <= CORDIC_GAIN;
            y_q     <= '0;
            z_q     <= CW'($signed(z_start));
            quad_q  <= quad_start;
            step_q  <= '0;
            state_q <= C_RUN;
          end
        end
        C_RUN: begin
          x_q    <= x_d;
          y_q    <= y_d;
          z_q    <= z_d;
          step_q <= step_q + STEP_W'(1);
          if (step_q == LAST_STEP) begin
            state_q <= C_FIX;
          end
        end
        C_FIX: begin
          // Turn the result back by the quadrant taken off at the start.
          case (quad_q)
            2'd0: begin
              cos_o <= x_q;
              sin_o <= y_q;
            end
            2'd1: begin
              cos_o <= -y_q;
              sin_o <= x_q;
            end
            2'd2: begin
              cos_o <= -x_q;
              sin_o <= -y_q;
            end
            default: begin
              cos_o <= y_q;
              sin_o <= -x_q;
            end
          endcase
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

endmodule

### rtl/planar_odometry_integrator_unit.sv
// Top level of the planar dead-reckoning odometry integrator.
// A report is taken only while the sequencer is idle, so a new report waits until the pose
// of the last one is in the output register. The rotator runs CORDIC_STEPS steps, capped at
// 32, one step per cycle, and nine products then share the one multiplier.
// A finished pose waits in the output register, and the next report is taken meanwhile.
// Reset (asynchronous, active low) clears x, y and heading to zero and empties the output.
module planar_odometry_integrator_unit #(
  parameter int unsigned CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  poi_in_if.sink    in_i,
  poi_out_if.source out_o
);
  import poi_pkg::*;

  // Widths of the intermediate quantities.
  localparam int unsigned ACC_W  = 64;             // exact velocity rotation sums
  localparam int unsigned ROT_W  = ACC_W - 30;     // rotated velocity, Q18.16
  localparam int unsigned STEP_W = 46;             // position step, Q22.24
  localparam int unsigned PROD_W = RATE_W + DT_W;  // yaw_rate times elapsed
  localparam int unsigned SUM_W  = 55;             // scaled heading step before rounding

  localparam logic signed [ACC_W-1:0]   ACC_HALF  = ACC_W'(64'sd1 <<< 29);
  localparam logic signed [MUL_P_W-1:0] STEP_HALF = MUL_P_W'(64'sd1 <<< 11);

  // Sequencer: each state that uses the multiplier names the product that it hands over.
  // A product is picked up by the state right after the one that issued it.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_VX_COS,
    ST_VY_SIN,
    ST_VX_SIN,
    ST_VY_COS,
    ST_RX_DT,
    ST_W_DT,
    ST_RY_DT,
    ST_POS_Y,
    ST_LO_T,
    ST_HI_T,
    ST_SUM,
    ST_YAW,
    ST_DONE
  } seq_state_e;

  seq_state_e state_q;

  // Report held for the whole computation.
  logic signed [VEL_W-1:0]  vx_q, vy_q;
  logic signed [RATE_W-1:0] w_q;
  logic        [DT_W-1:0]   dt_q;

  // Pose state.
  logic signed [POS_W-1:0] x_acc_q, y_acc_q;
  logic        [ANG_W-1:0] yaw_q;

  // Working registers.
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ROT_W-1:0]  rx_q, ry_q;
  logic signed [PROD_W-1:0] prod_q;
  logic        [PROD_W-1:0] mag_q;
  logic                     neg_q;
  logic        [SUM_W-1:0]  sum_q;

  // Output register.
  logic                    out_valid_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic        [ANG_W-1:0] heading_q;

  // Datapath wires.
  logic                       in_xfer;
  logic                       out_free;
  logic                       cordic_done;
  logic signed [CW-1:0]       cos_w, sin_w;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;
  logic signed [MUL_B_W-1:0]  dt_b;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [ROT_W-1:0]    rot_d;
  logic signed [MUL_P_W-1:0]  step_rnd;
  logic signed [STEP_W-1:0]   pos_step;
  logic signed [POS_W:0]      x_sum, y_sum;
  logic signed [POS_W-1:0]    x_acc_d, y_acc_d;
  logic        [PROD_W-1:0]   mag_d;
  logic        [SUM_W-1:0]    sum_rnd;
  logic        [ANG_W-1:0]    dyaw;
  logic        [ANG_W-1:0]    yaw_d;

  // Clamp a sum that is one bit wider than the position to the position range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.pos_x   = pos_x_q;
  assign out_o.pos_y   = pos_y_q;
  assign out_o.heading = heading_q;

  // The rotator starts on the heading held before this report, in the
  // same cycle as the transfer, so the old heading drives the position step.
  poi_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_xfer),
    .angle_i(yaw_q),
    .done_o (cordic_done),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  // Operand selection for the one multiplier. Elapsed time and the
  // heading scale factor are non-negative and enter zero extended.
  assign dt_b = MUL_B_W'(dt_q);

  always_comb begin
    case (state_q)
      ST_VX_COS: begin
        mul_a = MUL_A_W'(vx_q);
        mul_b = MUL_B_W'(cos_w);
      end
      ST_VY_SIN: begin
        mul_a = MUL_A_W'(vy_q);
        mul_b = MUL_B_W'(sin_w);
      end
      ST_VX_SIN: begin
        mul_a = MUL_A_W'(vx_q);
        mul_b = MUL_B_W'(sin_w);
      end
      ST_VY_COS: begin
        mul_a = MUL_A_W'(vy_q);
        mul_b = MUL_B_W'(cos_w);
      end
      ST_RX_DT: begin
        mul_a = MUL_A_W'(rx_q);
        mul_b = dt_b;
      end
      ST_W_DT: begin
        mul_a = MUL_A_W'(w_q);
        mul_b = dt_b;
      end
      ST_RY_DT: begin
        mul_a = MUL_A_W'(ry_q);
        mul_b = dt_b;
      end
      ST_LO_T: begin
        mul_a = MUL_A_W'(mag_q[ANG_W-1:0]);
        mul_b = MUL_B_W'(TURN_PER_RAD);
      end
      ST_HI_T: begin
        mul_a = MUL_A_W'(mag_q[PROD_W-1:ANG_W]);
        mul_b = MUL_B_W'(TURN_PER_RAD);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  poi_mult u_mult (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // Rotated velocity: the exact Q1.30 by Q16.16 sum, rounded half up to Q18.16.
  // Taking the upper bits of a two's complement word is the floor shift.
  assign acc_rnd = acc_q + ACC_HALF;
  assign rot_d   = acc_rnd[ACC_W-1:30];

  // Position step: velocity times elapsed, rounded half up from 2^-36 to 2^-24 m.
  // The same rounding serves x and y since their products arrive in different states.
  assign step_rnd = mul_p + STEP_HALF;
  assign pos_step = step_rnd[STEP_W+11:12];
  assign x_sum    = (POS_W+1)'(x_acc_q) + (POS_W+1)'(pos_step);
  assign y_sum    = (POS_W+1)'(y_acc_q) + (POS_W+1)'(pos_step);
  assign x_acc_d  = sat_pos(x_sum);
  assign y_acc_d  = sat_pos(y_sum);

  // Heading step: the magnitude of yaw_rate*elapsed is scaled in two halves,
  // the lower half keeping only its bits above 2^32, then rounded by 2^4 with
  // ties away from zero because the sign is put back afterwards.
  assign mag_d   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign sum_rnd = sum_q + SUM_W'(8);
  assign dyaw    = sum_rnd[ANG_W+3:4];
  assign yaw_d   = neg_q ? (yaw_q - dyaw) : (yaw_q + dyaw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      yaw_q       <= '0;
    end else begin
      // In the hand-over state the valid flag is set below instead.
      if (out_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            vx_q    <= in_i.vel_x;
            vy_q    <= in_i.vel_y;
            w_q     <= in_i.yaw_rate;
            dt_q    <= in_i.elapsed;
            state_q <= ST_ROTATE;
          end
        end
        ST_ROTATE: begin
          if (cordic_done) begin
            state_q <= ST_VX_COS;
          end
        end
        ST_VX_COS: begin
          state_q <= ST_VY_SIN;
        end
        ST_VY_SIN: begin
          acc_q   <= ACC_W'(mul_p);
          state_q <= ST_VX_SIN;
        end
        ST_VX_SIN: begin
          acc_q   <= acc_q - ACC_W'(mul_p);
          state_q <= ST_VY_COS;
        end
        ST_VY_COS: begin
          rx_q    <= rot_d;
          acc_q   <= ACC_W'(mul_p);
          state_q <= ST_RX_DT;
        end
        ST_RX_DT: begin
          acc_q   <= acc_q + ACC_W'(mul_p);
          state_q <= ST_W_DT;
        end
        ST_W_DT: begin
          ry_q    <= rot_d;
          x_acc_q <= x_acc_d;
          state_q <= ST_RY_DT;
        end
        ST_RY_DT: begin
          prod_q  <= PROD_W'(mul_p);
          state_q <= ST_POS_Y;
        end
        ST_POS_Y: begin
          y_acc_q <= y_acc_d;
          mag_q   <= mag_d;
          neg_q   <= prod_q[PROD_W-1];
          state_q <= ST_LO_T;
        end
        ST_LO_T: begin
          state_q <= ST_HI_T;
        end
        ST_HI_T: begin
          sum_q   <= SUM_W'(mul_p[61:32]);
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sum_q   <= sum_q + SUM_W'(mul_p[53:0]);
          state_q <= ST_YAW;
        end
        ST_YAW: begin
          yaw_q   <= yaw_d;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Hand the pose over once the output register is free.
          if (out_free) begin
            pos_x_q     <= x_acc_q;
            pos_y_q     <= y_acc_q;
            heading_q   <= yaw_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/poi_checker.sv
// Port-level assertions for the odometry integrator and their binding to the top level.
module poi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic       in_xfer, out_xfer;
  logic [2:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Reports taken whose pose has not yet been transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before its transfer");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("ready stayed high right after a report was taken");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result offered with no report outstanding");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more than two reports outstanding");

endmodule

bind planar_odometry_integrator_unit poi_checker u_poi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready)
);
